>>> design/ppcf_pkg.sv
// ----------------------------------------------------------------------------
// ppcf_pkg: shared types and helpers for the pair contact force block
// Configuration codes, the record passed from the front to the back, and
// the truncating fixed-point shift used by all products but the spring term.
// ----------------------------------------------------------------------------
package ppcf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PW            = 72;

    typedef enum logic [1:0] {
        CFG_RADIUS    = 2'd0,
        CFG_STIFFNESS = 2'd1,
        CFG_DAMPING   = 2'd2,
        CFG_FRICTION  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] radius;
        logic [31:0] stiffness;
        logic [31:0] damping;
        logic [31:0] friction;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
    } t_item;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic [32:0]        d;
        logic               contact;
    } t_pair;

    // Arithmetic shift right that rounds toward zero.
    function automatic logic signed [PW-1:0] tz_shift(input logic signed [PW-1:0] p,
                                                      input int unsigned sh);
        logic signed [PW-1:0] bias;
        bias = p[PW-1] ? ((PW'(1) << sh) - PW'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

endpackage

>>> design/particle_pair_contact_force.sv
// ----------------------------------------------------------------------------
// particle_pair_contact_force: 2-D spring-dashpot contact force on particle A
// Takes two particle states, returns the saturated contact force on A.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/tready       | tdata: 8 x 32-bit particle state
//  m_axis    | out       | m_axis_tvalid/tready       | tdata: force x,y; tuser: flags
//  cfg       | in        | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One beat per cycle in and out while nothing stalls. The path holds 37
//  front stages (differences, squares, sum, a 33-stage square root,
//  classify), one queue slot, an entry stage, FRAC_BITS + 1 divider
//  stages, nine product and sum stages and the output register. Reset
//  clears all valid bits and the queue, and loads the registers with
//  radius 1.0 and zero coefficients. A stall on m_axis holds the back
//  pipeline; the front keeps running until the queue fills.
//
module particle_pair_contact_force #(
    parameter int FRAC_BITS = ppcf_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // force_x, force_y
    output logic [63:0]  m_axis_tdata,
    // in_contact, saturated
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ppcf_pkg::*;

    t_cfg               r_cfg;
    t_item              w_item;
    logic               f_valid;
    logic               f_ready;
    t_pair              f_pair;
    logic               q_valid;
    logic               q_ready;
    t_pair              q_pair;
    logic signed [31:0] w_fx;
    logic signed [31:0] w_fy;
    logic               w_contact;
    logic               w_sat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius    <= 32'(1) << FRAC_BITS;
            r_cfg.stiffness <= '0;
            r_cfg.damping   <= '0;
            r_cfg.friction  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RADIUS:    r_cfg.radius    <= i_cfg_data;
                CFG_STIFFNESS: r_cfg.stiffness <= i_cfg_data;
                CFG_DAMPING:   r_cfg.damping   <= i_cfg_data;
                CFG_FRICTION:  r_cfg.friction  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack the input beat, first field in the low bits
    always_comb begin
        w_item.a_pos_x = s_axis_tdata[31:0];
        w_item.a_pos_y = s_axis_tdata[63:32];
        w_item.a_vel_x = s_axis_tdata[95:64];
        w_item.a_vel_y = s_axis_tdata[127:96];
        w_item.b_pos_x = s_axis_tdata[159:128];
        w_item.b_pos_y = s_axis_tdata[191:160];
        w_item.b_vel_x = s_axis_tdata[223:192];
        w_item.b_vel_y = s_axis_tdata[255:224];
    end

    ppcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_two_r ({r_cfg.radius, 1'b0}),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_item),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_pair  (f_pair)
    );

    ppcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_pair),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_pair)
    );

    ppcf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_pair      (q_pair),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_force_x   (w_fx),
        .o_force_y   (w_fy),
        .o_contact   (w_contact),
        .o_saturated (w_sat)
    );

    assign m_axis_tdata = {w_fy, w_fx};
    assign m_axis_tuser = {w_sat, w_contact};

`ifndef SYNTHESIS
    // a clipped force only comes from a pair in contact
    a_sat_needs_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("saturated flag without contact");

    // no contact gives zero force
    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("nonzero force without contact");

    // a clipped beat carries a component at a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[31:0] == 32'h7FFFFFFF) || (m_axis_tdata[31:0] == 32'h80000000) ||
            (m_axis_tdata[63:32] == 32'h7FFFFFFF) || (m_axis_tdata[63:32] == 32'h80000000))
        else $error("saturated flag without a limit value");
`endif

endmodule

>>> design/ppcf_front.sv
// ----------------------------------------------------------------------------
// ppcf_front: differences, distance and contact classification
// Pipelined squares, sum and a one-bit-per-stage square root.
// ----------------------------------------------------------------------------
module ppcf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [32:0]     i_two_r,
    input  logic            i_valid,
    output logic            o_ready,
    input  ppcf_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output ppcf_pkg::t_pair o_pair
);
    import ppcf_pkg::*;

    localparam int SQ_STEPS = 33;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 4;
    localparam int NV       = SQ_STEPS + 4;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
    } t_diff;

    typedef struct packed {
        t_diff               df;
        logic [RAD_W-1:0]    rad;
        logic [SQ_STEPS-1:0] root;
        logic [REM_W-1:0]    rem;
    } t_sq;

    logic          en;
    logic [NV-1:0] r_v;
    t_diff         r_df;
    t_diff         r_d1;
    logic [65:0]   r_sqx;
    logic [65:0]   r_sqy;
    t_sq           r_sq [SQ_STEPS+1];
    t_pair         r_pair;
    logic [32:0]   w_magx;
    logic [32:0]   w_magy;

    assign en      = !r_v[NV-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NV-1];
    assign o_pair  = r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NV-2:0], i_valid};
        end
    end

    always_comb begin
        w_magx = r_df.dx[32] ? 33'(-r_df.dx) : 33'(r_df.dx);
        w_magy = r_df.dy[32] ? 33'(-r_df.dy) : 33'(r_df.dy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_df.dx  <= 33'(i_item.b_pos_x) - 33'(i_item.a_pos_x);
            r_df.dy  <= 33'(i_item.b_pos_y) - 33'(i_item.a_pos_y);
            r_df.rvx <= 33'(i_item.b_vel_x) - 33'(i_item.a_vel_x);
            r_df.rvy <= 33'(i_item.b_vel_y) - 33'(i_item.a_vel_y);
            r_d1     <= r_df;
            r_sqx    <= 66'(w_magx) * 66'(w_magx);
            r_sqy    <= 66'(w_magy) * 66'(w_magy);
            r_sq[0].df   <= r_d1;
            r_sq[0].rad  <= r_sqx + r_sqy;
            r_sq[0].root <= '0;
            r_sq[0].rem  <= '0;
        end
    end

    // one root bit per stage: bring down two radicand bits, try root*4+1
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [REM_W-1:0] w_rem;
        logic [REM_W-1:0] w_trial;
        always_comb begin
            w_rem   = {r_sq[k].rem[REM_W-3:0], r_sq[k].rad[RAD_W-1 -: 2]};
            w_trial = {{(REM_W-SQ_STEPS-2){1'b0}}, r_sq[k].root, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k+1].df  <= r_sq[k].df;
                r_sq[k+1].rad <= {r_sq[k].rad[RAD_W-3:0], 2'b00};
                if (w_rem >= w_trial) begin
                    r_sq[k+1].rem  <= w_rem - w_trial;
                    r_sq[k+1].root <= {r_sq[k].root[SQ_STEPS-2:0], 1'b1};
                end else begin
                    r_sq[k+1].rem  <= w_rem;
                    r_sq[k+1].root <= {r_sq[k].root[SQ_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pair.dx      <= r_sq[SQ_STEPS].df.dx;
            r_pair.dy      <= r_sq[SQ_STEPS].df.dy;
            r_pair.rvx     <= r_sq[SQ_STEPS].df.rvx;
            r_pair.rvy     <= r_sq[SQ_STEPS].df.rvy;
            r_pair.d       <= r_sq[SQ_STEPS].root;
            r_pair.contact <= (r_sq[SQ_STEPS].root != '0) && (r_sq[SQ_STEPS].root < i_two_r);
        end
    end

endmodule

>>> design/ppcf_queue.sv
// ----------------------------------------------------------------------------
// ppcf_queue: short queue between the front and the back
// Register FIFO of classified pairs so either side may stall on its own.
// ----------------------------------------------------------------------------
module ppcf_queue #(
    parameter int DEPTH = ppcf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ppcf_pkg::t_pair i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ppcf_pkg::t_pair o_data
);
    import ppcf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW:0]   r_count;
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    t_pair         r_mem [DEPTH];
    logic          push;
    logic          pop;

    assign o_ready = r_count != (AW+1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> design/ppcf_back.sv
// ----------------------------------------------------------------------------
// ppcf_back: unit normal, force terms and saturation
// Restoring divider stages for the normal, then products and sums.
// ----------------------------------------------------------------------------
module ppcf_back #(
    parameter int FRAC_BITS = ppcf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppcf_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  ppcf_pkg::t_pair    i_pair,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic               o_contact,
    output logic               o_saturated
);
    import ppcf_pkg::*;

    localparam int QW    = FRAC_BITS + 1;
    localparam int NW    = FRAC_BITS + 2;
    localparam int SPW   = 66 - FRAC_BITS;
    localparam int VNW   = 35;
    localparam int TW    = 36;
    localparam int NDIV  = FRAC_BITS + 1;
    localparam int NMATH = 9;
    localparam int NV    = NDIV + NMATH + 2;

    typedef struct packed {
        logic [32:0]        magx;
        logic [32:0]        magy;
        logic               sx;
        logic               sy;
        logic [32:0]        d;
        logic               contact;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic [32:0]        remx;
        logic [32:0]        remy;
        logic [QW-1:0]      qx;
        logic [QW-1:0]      qy;
    } t_div;

    typedef struct packed {
        logic               contact;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic [33:0]        gap;
        logic signed [PW-1:0] p0;
        logic signed [PW-1:0] p1;
        logic signed [PW-1:0] p2;
        logic signed [PW-1:0] p3;
        logic signed [VNW-1:0] vn;
        logic [SPW-1:0]     sp;
        logic signed [VNW-1:0] nvx;
        logic signed [VNW-1:0] nvy;
        logic signed [63:0] spnx;
        logic signed [63:0] spny;
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [63:0] dampx;
        logic signed [63:0] dampy;
        logic signed [63:0] fricx;
        logic signed [63:0] fricy;
        logic signed [63:0] fx;
        logic signed [63:0] fy;
    } t_math;

    logic          en;
    logic [NV-1:0] r_v;
    t_div          r_dv [NDIV+1];
    t_math         r_m  [NMATH+1];
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic          r_contact;
    logic          r_sat;
    logic [32:0]   w_two_r;
    logic signed [31:0] w_fx;
    logic signed [31:0] w_fy;
    logic          w_sat;

    assign en          = !r_v[NV-1] || i_ready;
    assign o_ready     = en;
    assign o_valid     = r_v[NV-1];
    assign o_force_x   = r_fx;
    assign o_force_y   = r_fy;
    assign o_contact   = r_contact;
    assign o_saturated = r_sat;
    assign w_two_r     = {i_cfg.radius, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NV-2:0], i_valid};
        end
    end

    // entry: magnitudes and the first partial remainder
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].magx    <= i_pair.dx[32] ? 33'(-i_pair.dx) : 33'(i_pair.dx);
            r_dv[0].magy    <= i_pair.dy[32] ? 33'(-i_pair.dy) : 33'(i_pair.dy);
            r_dv[0].remx    <= (i_pair.dx[32] ? 33'(-i_pair.dx) : 33'(i_pair.dx)) >> 1;
            r_dv[0].remy    <= (i_pair.dy[32] ? 33'(-i_pair.dy) : 33'(i_pair.dy)) >> 1;
            r_dv[0].sx      <= i_pair.dx[32];
            r_dv[0].sy      <= i_pair.dy[32];
            r_dv[0].d       <= i_pair.d;
            r_dv[0].contact <= i_pair.contact;
            r_dv[0].rvx     <= i_pair.rvx;
            r_dv[0].rvy     <= i_pair.rvy;
            r_dv[0].qx      <= '0;
            r_dv[0].qy      <= '0;
        end
    end

    // one quotient bit per stage for each axis
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [33:0] w_nx;
        logic [33:0] w_ny;
        logic        w_gex;
        logic        w_gey;
        always_comb begin
            w_nx  = {r_dv[k].remx, (k == 0) ? r_dv[k].magx[0] : 1'b0};
            w_ny  = {r_dv[k].remy, (k == 0) ? r_dv[k].magy[0] : 1'b0};
            w_gex = w_nx >= {1'b0, r_dv[k].d};
            w_gey = w_ny >= {1'b0, r_dv[k].d};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k+1]      <= r_dv[k];
                r_dv[k+1].remx <= 33'(w_gex ? w_nx - {1'b0, r_dv[k].d} : w_nx);
                r_dv[k+1].remy <= 33'(w_gey ? w_ny - {1'b0, r_dv[k].d} : w_ny);
                r_dv[k+1].qx   <= {r_dv[k].qx[QW-2:0], w_gex};
                r_dv[k+1].qy   <= {r_dv[k].qy[QW-2:0], w_gey};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // signed normal and overlap
            r_m[1].contact <= r_dv[NDIV].contact;
            r_m[1].rvx     <= r_dv[NDIV].rvx;
            r_m[1].rvy     <= r_dv[NDIV].rvy;
            r_m[1].nx      <= r_dv[NDIV].sx ? -$signed({1'b0, r_dv[NDIV].qx})
                                            : $signed({1'b0, r_dv[NDIV].qx});
            r_m[1].ny      <= r_dv[NDIV].sy ? -$signed({1'b0, r_dv[NDIV].qy})
                                            : $signed({1'b0, r_dv[NDIV].qy});
            r_m[1].gap     <= {1'b0, w_two_r} - {1'b0, r_dv[NDIV].d};

            // normal velocity products and spring product
            r_m[2]    <= r_m[1];
            r_m[2].p0 <= PW'(r_m[1].rvx) * PW'(r_m[1].nx);
            r_m[2].p1 <= PW'(r_m[1].rvy) * PW'(r_m[1].ny);
            r_m[2].p2 <= PW'($signed({1'b0, i_cfg.stiffness})) * PW'($signed({1'b0, r_m[1].gap}));

            r_m[3]    <= r_m[2];
            r_m[3].vn <= VNW'(tz_shift(r_m[2].p0, FRAC_BITS) + tz_shift(r_m[2].p1, FRAC_BITS));
            r_m[3].sp <= SPW'(r_m[2].p2 >>> FRAC_BITS);

            r_m[4]    <= r_m[3];
            r_m[4].p0 <= PW'(r_m[3].vn) * PW'(r_m[3].nx);
            r_m[4].p1 <= PW'(r_m[3].vn) * PW'(r_m[3].ny);
            r_m[4].p2 <= PW'($signed({1'b0, r_m[3].sp})) * PW'(r_m[3].nx);
            r_m[4].p3 <= PW'($signed({1'b0, r_m[3].sp})) * PW'(r_m[3].ny);

            r_m[5]      <= r_m[4];
            r_m[5].nvx  <= VNW'(tz_shift(r_m[4].p0, FRAC_BITS));
            r_m[5].nvy  <= VNW'(tz_shift(r_m[4].p1, FRAC_BITS));
            r_m[5].spnx <= 64'(tz_shift(r_m[4].p2, FRAC_BITS));
            r_m[5].spny <= 64'(tz_shift(r_m[4].p3, FRAC_BITS));

            // tangential part of the relative velocity
            r_m[6]    <= r_m[5];
            r_m[6].tx <= TW'(r_m[5].rvx) - TW'(r_m[5].nvx);
            r_m[6].ty <= TW'(r_m[5].rvy) - TW'(r_m[5].nvy);

            r_m[7]    <= r_m[6];
            r_m[7].p0 <= PW'($signed({1'b0, i_cfg.damping})) * PW'(r_m[6].nvx);
            r_m[7].p1 <= PW'($signed({1'b0, i_cfg.damping})) * PW'(r_m[6].nvy);
            r_m[7].p2 <= PW'($signed({1'b0, i_cfg.friction})) * PW'(r_m[6].tx);
            r_m[7].p3 <= PW'($signed({1'b0, i_cfg.friction})) * PW'(r_m[6].ty);

            r_m[8]       <= r_m[7];
            r_m[8].dampx <= 64'(tz_shift(r_m[7].p0, FRAC_BITS));
            r_m[8].dampy <= 64'(tz_shift(r_m[7].p1, FRAC_BITS));
            r_m[8].fricx <= 64'(tz_shift(r_m[7].p2, FRAC_BITS));
            r_m[8].fricy <= 64'(tz_shift(r_m[7].p3, FRAC_BITS));

            // damping applies only while approaching
            r_m[9]    <= r_m[8];
            r_m[9].fx <= r_m[8].fricx - r_m[8].spnx
                         + (r_m[8].vn[VNW-1] ? r_m[8].dampx : 64'sd0);
            r_m[9].fy <= r_m[8].fricy - r_m[8].spny
                         + (r_m[8].vn[VNW-1] ? r_m[8].dampy : 64'sd0);
        end
    end

    always_comb begin
        w_sat = 1'b0;
        if (r_m[9].fx > 64'sd2147483647) begin
            w_fx  = 32'sh7FFFFFFF;
            w_sat = 1'b1;
        end else if (r_m[9].fx < -64'sd2147483648) begin
            w_fx  = 32'sh80000000;
            w_sat = 1'b1;
        end else begin
            w_fx = 32'(r_m[9].fx);
        end
        if (r_m[9].fy > 64'sd2147483647) begin
            w_fy  = 32'sh7FFFFFFF;
            w_sat = 1'b1;
        end else if (r_m[9].fy < -64'sd2147483648) begin
            w_fy  = 32'sh80000000;
            w_sat = 1'b1;
        end else begin
            w_fy = 32'(r_m[9].fy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_contact <= r_m[9].contact;
            r_fx      <= r_m[9].contact ? w_fx : 32'sd0;
            r_fy      <= r_m[9].contact ? w_fy : 32'sd0;
            r_sat     <= r_m[9].contact && w_sat;
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: pair contact force checker
// Drives candidate particle pairs into the block, predicts each contact
// force from the spring, damping and friction terms, and compares every
// output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ppcf_pkg::*;

    localparam logic [127:0] PROD_CAP = 128'h0FFF_FFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               contact;
        logic               sat;
    } t_force;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    // Register copies for the predictor
    logic [31:0] radius_q, stiff_q, damp_q, fric_q;

    t_force force_fifo[$];
    int     mismatches;
    bit     quiet;          // no idling on either side while set
    int     hold_left;      // receiver hold-off, counted down at posedge
    int     rx_stall;

    particle_pair_contact_force dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] ma, mb, p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        p   = (ma * mb) >> 16;
        if (p > PROD_CAP) p = PROD_CAP;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint pair_distance(longint dx, longint dy);
        logic [127:0] sum, c;
        logic [63:0]  r;
        sum = 128'($signed(dx)) * 128'($signed(dx)) + 128'($signed(dy)) * 128'($signed(dy));
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            c = 128'(r | (64'd1 << b));
            if (c * c <= sum) r = c[63:0];
        end
        return longint'(r);
    endfunction

    function automatic longint normal_part(longint delta, longint d);
        longint q;
        q = ((delta < 0 ? -delta : delta) << 16) / d;
        return delta < 0 ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_force contact_force(t_item it);
        longint dx, dy, rvx, rvy, two_r, d, nx, ny, vn, nvx, nvy, sp, fx, fy;
        t_force f;
        f   = '0;
        dx  = longint'(it.b_pos_x) - longint'(it.a_pos_x);
        dy  = longint'(it.b_pos_y) - longint'(it.a_pos_y);
        rvx = longint'(it.b_vel_x) - longint'(it.a_vel_x);
        rvy = longint'(it.b_vel_y) - longint'(it.a_vel_y);
        two_r = 2 * longint'({32'd0, radius_q});
        d = pair_distance(dx, dy);
        if (d == 0 || d >= two_r) return f;
        nx  = normal_part(dx, d);
        ny  = normal_part(dy, d);
        vn  = fx_mul(rvx, nx) + fx_mul(rvy, ny);
        nvx = fx_mul(vn, nx);
        nvy = fx_mul(vn, ny);
        sp  = fx_mul(longint'({32'd0, stiff_q}), two_r - d);
        fx  = -fx_mul(sp, nx);
        fy  = -fx_mul(sp, ny);
        // damping only while the pair closes in
        if (vn < 0) begin
            fx += fx_mul(longint'({32'd0, damp_q}), nvx);
            fy += fx_mul(longint'({32'd0, damp_q}), nvy);
        end
        fx += fx_mul(longint'({32'd0, fric_q}), rvx - nvx);
        fy += fx_mul(longint'({32'd0, fric_q}), rvy - nvy);
        f.sat = 1'b0;
        f.fx = clamp32(fx, f.sat);
        f.fy = clamp32(fy, f.sat);
        f.contact = 1'b1;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Receiver: random stalls, plus the long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_force got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tuser[1]};
            if (force_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat fx=%h fy=%h",
                                               got.fx, got.fy);
            end else begin
                want = force_fifo.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp fx=%h fy=%h c=%b s=%b got fx=%h fy=%h c=%b s=%b",
                                 want.fx, want.fy, want.contact, want.sat,
                                 got.fx, got.fy, got.contact, got.sat);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_pair(t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.b_vel_y, it.b_vel_x, it.b_pos_y, it.b_pos_x,
                          it.a_vel_y, it.a_vel_x, it.a_pos_y, it.a_pos_x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        force_fifo.push_back(contact_force(it));
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold until every result is back, then let the pipeline settle
    task automatic wait_idle();
        drop_valid();
        while (force_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RADIUS:    radius_q = val;
            CFG_STIFFNESS: stiff_q  = val;
            CFG_DAMPING:   damp_q   = val;
            CFG_FRICTION:  fric_q   = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_coeffs(logic [31:0] r, logic [31:0] k, logic [31:0] c, logic [31:0] f);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_STIFFNESS, k);
        write_reg(CFG_DAMPING, c);
        write_reg(CFG_FRICTION, f);
    endtask

    function automatic logic [31:0] rnd_scaled();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] rnd_offset();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    // Mostly near pairs with random content; some full-range noise
    function automatic t_item rnd_pair();
        t_item it;
        it.a_pos_x = $urandom;
        it.a_pos_y = $urandom;
        it.a_vel_x = ($urandom_range(0, 3) == 0) ? $urandom : rnd_offset();
        it.a_vel_y = ($urandom_range(0, 3) == 0) ? $urandom : rnd_offset();
        it.b_vel_x = ($urandom_range(0, 3) == 0) ? $urandom : rnd_offset();
        it.b_vel_y = ($urandom_range(0, 3) == 0) ? $urandom : rnd_offset();
        if ($urandom_range(0, 9) < 8) begin
            it.b_pos_x = it.a_pos_x + rnd_offset();
            it.b_pos_y = it.a_pos_y + rnd_offset();
        end else begin
            it.b_pos_x = $urandom;
            it.b_pos_y = $urandom;
        end
        return it;
    endfunction

    function automatic t_item mk(int ax, int ay, int avx, int avy,
                                 int bx, int by, int bvx, int bvy);
        t_item it;
        it = {ax, ay, avx, avy, bx, by, bvx, bvy};
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // reset registers: radius 1.0, no coefficients
        send_pair(mk(0, 0, 0, 0, 32'h8000, 0, 0, 0));
        wait_idle();
        set_coeffs(32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_8000);
        // equal positions
        send_pair(mk(32'h0001_0000, 32'h0001_0000, 5, 5, 32'h0001_0000, 32'h0001_0000, 0, 0));
        // exactly touching, and just inside
        send_pair(mk(0, 0, 0, 0, 32'h0002_0000, 0, 0, 0));
        send_pair(mk(0, 0, 0, 0, 32'h0001_FFFF, 0, 0, 0));
        // far apart
        send_pair(mk(0, 0, 0, 0, 32'h0010_0000, 32'h0010_0000, 0, 0));
        // approaching and separating, with tangential slip
        send_pair(mk(0, 0, 32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 32'h0000_8000,
                     -32'sh0001_0000, 0));
        send_pair(mk(0, 0, -32'sh0001_0000, 32'h0003_0000, 32'h0000_C000, -32'sh0000_8000,
                     32'h0001_0000, 0));
        // one raw unit apart
        send_pair(mk(7, 7, 0, 0, 8, 7, 0, 0));
        // field extremes
        send_pair(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        wait_idle();
        // huge radius and coefficients: contact nearly everywhere, saturating
        set_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_pair(mk(0, 0, 32'h7FFF_FFFF, 0, 32'h0000_0100, 32'h0000_0100, 32'h8000_0000, 5));
        send_pair(mk(0, 0, 0, 0, 1, 0, 0, 0));
        wait_idle();
        // zero radius: never in contact
        set_coeffs(32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_pair(mk(0, 0, 0, 0, 1, 1, 9, 9));
        wait_idle();
    endtask

    task automatic test_random(int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 80 == 0) begin
                wait_idle();
                set_coeffs(($urandom_range(0, 7) == 0) ? $urandom : rnd_scaled(),
                           rnd_scaled(), rnd_scaled(), rnd_scaled());
                quiet = ($urandom_range(0, 3) == 0);
            end
            send_pair(rnd_pair());
        end
        quiet = 1'b0;
        wait_idle();
    endtask

    // Receiver stops for a long stretch while pairs keep coming in
    task automatic test_backpressure();
        set_coeffs(32'h0100_0000, rnd_scaled(), rnd_scaled(), rnd_scaled());
        @(negedge i_clk);
        hold_left = 400;
        for (int i = 0; i < 120; i++) send_pair(rnd_pair());
        wait_idle();
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++) send_pair(rnd_pair());
        wait_idle();
        for (int i = 0; i < 20; i++) send_pair(rnd_pair());
        wait_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_RADIUS;
        i_cfg_data    = '0;
        radius_q      = 32'h0001_0000;
        stiff_q       = '0;
        damp_q        = '0;
        fric_q        = '0;
        mismatches    = 0;
        quiet         = 1'b0;
        hold_left     = 0;
        rx_stall      = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(400);
        test_backpressure();
        test_drain_pause();

        if (mismatches == 0 && force_fifo.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
design/ppcf_pkg.sv
design/ppcf_front.sv
design/ppcf_queue.sv
design/ppcf_back.sv
design/particle_pair_contact_force.sv
dv/testbench.sv
